@@ design/asmb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmb_pkg
// shared widths, cordic constants and the atan table
// ----------------------------------------------------------------------------
package asmb_pkg;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned ATAN_N = 32;
	localparam logic [63:0] DEG_TO_RAD_Q32 = 64'd74961321;
	localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

	typedef logic signed [WORD_W-1:0] word_t;

	// one layer placement
	typedef struct packed {
		word_t rotation_deg;
		word_t pos_x;
		word_t pos_y;
		word_t skew_factor;
		word_t scale_x;
		word_t scale_y;
	} place_t;

	// one matrix
	typedef struct packed {
		word_t coef_a;
		word_t coef_b;
		word_t coef_c;
		word_t coef_d;
		word_t coef_e;
		word_t coef_f;
	} coef_t;

	// payload that travels along the cordic chain
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic neg_cos;
		word_t pos_x;
		word_t pos_y;
		word_t skew_factor;
		word_t scale_x;
		word_t scale_y;
	} rot_t;

	// truncated q2.30 radians of atan(2^-i)
	function automatic logic signed [33:0] atan_q30(input int unsigned i);
		logic [31:0] v;
		unique case (i)
			0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
			18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
			21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
			24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
			27: v = 32'h00000007; 28: v = 32'h00000003; 29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return $signed({2'b00, v});
	endfunction
endpackage

@@ design/asmb_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmb_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface asmb_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/asmb_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmb_cordic_cell
// one cordic micro-rotation with its pipeline register
// ----------------------------------------------------------------------------
module asmb_cordic_cell #(
	parameter int unsigned STAGE = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input asmb_pkg::rot_t din,
	output logic vld_q,
	output asmb_pkg::rot_t dout_q
);
	import asmb_pkg::*;

	rot_t nxt;
	logic signed [33:0] dx, dy;

	always_comb begin
		dx = din.y >>> STAGE;
		dy = din.x >>> STAGE;
		nxt = din;
		if (STAGE < ATAN_N) begin
			if (!din.z[33]) begin
				nxt.x = din.x - dx;
				nxt.y = din.y + dy;
				nxt.z = din.z - atan_q30(STAGE);
			end else begin
				nxt.x = din.x + dx;
				nxt.y = din.y - dy;
				nxt.z = din.z + atan_q30(STAGE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= nxt;
		end
	end
endmodule

@@ design/affine_shape_matrix_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_shape_matrix_builder
// builds the 2d affine matrix translate*rotate*skew*scale per layer
// ----------------------------------------------------------------------------
// path: an input beat passes through s1 to s4, the cordic cells, m1 to m3 and the output register
// throughput: one beat per cycle; whole pipeline advances together and stalls
// only when the output register is full and not taken
// reset: arst_n clears all valid flags; payload registers are not reset
module affine_shape_matrix_builder #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	asmb_stream_if.sink in_ch,
	asmb_stream_if.source out_ch
);
	import asmb_pkg::*;

	localparam logic signed [63:0] PERIOD = 64'sd360 <<< FRAC_BITS;
	localparam logic signed [63:0] Q90 = 64'sd90 <<< FRAC_BITS;
	localparam logic signed [63:0] Q180 = 64'sd180 <<< FRAC_BITS;
	localparam logic signed [63:0] Q270 = 64'sd270 <<< FRAC_BITS;
	localparam logic signed [63:0] LIM = 64'sh0_FFFF_FFFF;
	// 32768 full turns in whole degrees, keeps the biased integer part positive
	localparam logic signed [31:0] ANGLE_BIAS = 32'sd11796480;
	// ceil(2^34 / 360), exact floor division for every biased value below 2^25
	localparam logic [50:0] RECIP_360 = 51'd47721859;
	localparam logic [63:0] LO_MASK = (64'd1 << FRAC_BITS) - 64'd1;

	// whole pipe moves when the output slot is free or being drained
	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	place_t pin;
	assign pin = in_ch.data;

	// ---------------- s1: angle range reduction step one ----------------
	// split the angle into whole degrees and fraction; the whole degrees get a
	// positive bias of full turns and are divided by 360 with a reciprocal
	logic signed [31:0] hi_deg;
	logic [24:0] hoff;
	logic [50:0] qp;
	logic v_s1;
	logic [24:0] hoff_s1;
	logic [16:0] q_s1;
	place_t p_s1;

	always_comb begin
		hi_deg = $signed(pin.rotation_deg) >>> FRAC_BITS;
		hoff = 25'(hi_deg + ANGLE_BIAS);
		qp = 51'(hoff) * RECIP_360;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hoff_s1 <= hoff;
			q_s1 <= qp[50:34];
			p_s1 <= pin;
		end
	end

	// ---------------- s2: finish modulo ----------------
	// whole degrees mod 360 back on top of the untouched fraction bits
	logic [24:0] rem25;
	logic signed [63:0] m2;
	logic v_s2;
	logic signed [63:0] m_s2;
	place_t p_s2;
	always_comb begin
		rem25 = hoff_s1 - 25'(q_s1 * 25'd360);
		m2 = $signed((64'(rem25) << FRAC_BITS) | ({32'd0, p_s1.rotation_deg} & LO_MASK));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= m2;
			p_s2 <= p_s1;
		end
	end

	// ---------------- s3: quadrant fold and magnitude ----------------
	logic signed [63:0] mf;
	logic nc;
	logic v_s3, neg_s3, nc_s3;
	logic [31:0] mag_s3;
	place_t p_s3;
	always_comb begin
		mf = m_s2;
		nc = 1'b0;
		if (mf >= Q90 && mf < Q270) begin
			mf = Q180 - mf;
			nc = 1'b1;
		end else if (mf >= Q270) begin
			mf = mf - PERIOD;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= mf[63];
			nc_s3 <= nc;
			mag_s3 <= mf[63] ? 32'(-mf) : 32'(mf);
			p_s3 <= p_s2;
		end
	end

	// ---------------- s4: degrees to radians ----------------
	logic [63:0] radp;
	logic v_s4;
	rot_t r_s4;
	always_comb radp = ({32'd0, mag_s3} * DEG_TO_RAD_Q32) >> (FRAC_BITS + 2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s4.x <= CORDIC_INV_GAIN;
			r_s4.y <= '0;
			r_s4.z <= neg_s3 ? -$signed(radp[33:0]) : $signed(radp[33:0]);
			r_s4.neg_cos <= nc_s3;
			r_s4.pos_x <= p_s3.pos_x;
			r_s4.pos_y <= p_s3.pos_y;
			r_s4.skew_factor <= p_s3.skew_factor;
			r_s4.scale_x <= p_s3.scale_x;
			r_s4.scale_y <= p_s3.scale_y;
		end
	end

	// ---------------- cordic chain of cells ----------------
	logic v_c [CORDIC_STAGES+1];
	rot_t r_c [CORDIC_STAGES+1];
	assign v_c[0] = v_s4;
	assign r_c[0] = r_s4;
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		asmb_cordic_cell #(.STAGE(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(v_c[g]), .din(r_c[g]),
			.vld_q(v_c[g+1]), .dout_q(r_c[g+1])
		);
	end

	rot_t rc;
	logic signed [33:0] cs, sn;
	assign rc = r_c[CORDIC_STAGES];
	assign cs = rc.neg_cos ? -rc.x : rc.x;
	assign sn = rc.y;

	// ---------------- m1: products with cos/sin ----------------
	logic v_m1;
	logic signed [65:0] cs_skew_m1, sn_skew_m1, a_m1, c_m1;
	logic signed [33:0] cs_m1, sn_m1;
	word_t sy_m1, px_m1, py_m1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m1 <= 1'b0;
		else if (en) v_m1 <= v_c[CORDIC_STAGES];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cs_skew_m1 <= 66'(cs) * 66'(rc.skew_factor);
			sn_skew_m1 <= 66'(sn) * 66'(rc.skew_factor);
			a_m1 <= 66'(cs) * 66'(rc.scale_x);
			c_m1 <= 66'(sn) * 66'(rc.scale_x);
			cs_m1 <= cs;
			sn_m1 <= sn;
			sy_m1 <= rc.scale_y;
			px_m1 <= rc.pos_x;
			py_m1 <= rc.pos_y;
		end
	end

	function automatic logic signed [63:0] rnd(input logic signed [65:0] v, input int s);
		logic signed [65:0] t;
		t = (v + (66'sd1 <<< (s - 1))) >>> s;
		return t[63:0];
	endfunction
	function automatic word_t sat(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// ---------------- m2: inner terms ----------------
	logic v_m2;
	logic signed [33:0] tb_m2, td_m2;
	word_t a_m2, c_m2, sy_m2, px_m2, py_m2;
	logic signed [63:0] tbr, tdr, tbc, tdc;
	always_comb begin
		tbr = rnd(cs_skew_m1 - (66'(sn_m1) <<< FRAC_BITS), 30);
		tdr = rnd(sn_skew_m1 + (66'(cs_m1) <<< FRAC_BITS), 30);
		tbc = tbr > LIM ? LIM : (tbr < -LIM ? -LIM : tbr);
		tdc = tdr > LIM ? LIM : (tdr < -LIM ? -LIM : tdr);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m2 <= 1'b0;
		else if (en) v_m2 <= v_m1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tb_m2 <= tbc[33:0];
			td_m2 <= tdc[33:0];
			a_m2 <= sat(rnd(a_m1, 30));
			c_m2 <= sat(rnd(c_m1, 30));
			sy_m2 <= sy_m1;
			px_m2 <= px_m1;
			py_m2 <= py_m1;
		end
	end

	// ---------------- m3: scale_y products ----------------
	logic v_m3;
	logic signed [65:0] b_m3, d_m3;
	word_t a_m3, c_m3, px_m3, py_m3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m3 <= 1'b0;
		else if (en) v_m3 <= v_m2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b_m3 <= 66'(tb_m2) * 66'(sy_m2);
			d_m3 <= 66'(td_m2) * 66'(sy_m2);
			a_m3 <= a_m2;
			c_m3 <= c_m2;
			px_m3 <= px_m2;
			py_m3 <= py_m2;
		end
	end

	// ---------------- output register ----------------
	coef_t res_q;
	logic vout_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout_q <= 1'b0;
		else if (en) vout_q <= v_m3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			res_q.coef_a <= a_m3;
			res_q.coef_b <= sat(rnd(b_m3, FRAC_BITS));
			res_q.coef_c <= c_m3;
			res_q.coef_d <= sat(rnd(d_m3, FRAC_BITS));
			res_q.coef_e <= px_m3;
			res_q.coef_f <= py_m3;
		end
	end
	assign out_ch.valid = vout_q;
	assign out_ch.data = res_q;
endmodule
